// ----- design/assert_macros.svh -----
// Assertion macros used by the rotation unit top module.
// Included by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

// ----- design/v3rot_pkg.sv -----
// Package of the vector rotation unit: types, constants and the arctangent table.
// No dependencies.
`default_nettype none
package v3rot_pkg;
  localparam int AngW = 26;
  localparam int AxisW = 32;
  localparam int ZW = 36;
  localparam int CsW = 34;
  localparam int MW = 36;
  localparam logic signed [ZW-1:0] Deg90 = 36'sd5898240;
  localparam logic signed [ZW-1:0] Deg180 = 36'sd11796480;
  localparam logic signed [ZW-1:0] Deg360 = 36'sd23592960;
  localparam logic signed [CsW-1:0] InvGain = 34'sd652032874;
  localparam logic signed [CsW-1:0] OneQ30 = 34'sd1073741824;

  typedef enum logic [1:0] {
    OP_ROT_X = 2'd0,
    OP_ROT_Y = 2'd1,
    OP_ROT_Z = 2'd2,
    OP_AXIS  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic                   flip;
    logic                   exact;
    logic signed [CsW-1:0]  ex_s;
    logic signed [CsW-1:0]  ex_c;
    logic signed [AxisW-1:0] ux;
    logic signed [AxisW-1:0] uy;
    logic signed [AxisW-1:0] uz;
  } ctl_t;

  function automatic logic signed [ZW-1:0] atan_f(input int i);
    logic signed [ZW-1:0] r;
    begin
      unique case (i)
        0: r = 36'sd754974720;   1: r = 36'sd445687602;  2: r = 36'sd235489088;
        3: r = 36'sd119537938;   4: r = 36'sd60000934;   5: r = 36'sd30029717;
        6: r = 36'sd15018523;    7: r = 36'sd7509720;    8: r = 36'sd3754917;
        9: r = 36'sd1877466;    10: r = 36'sd938734;    11: r = 36'sd469367;
        12: r = 36'sd234684;    13: r = 36'sd117342;    14: r = 36'sd58671;
        15: r = 36'sd29335;     16: r = 36'sd14668;     17: r = 36'sd7334;
        18: r = 36'sd3667;      19: r = 36'sd1833;      20: r = 36'sd917;
        21: r = 36'sd458;       22: r = 36'sd229;       23: r = 36'sd115;
        24: r = 36'sd57;        25: r = 36'sd29;        26: r = 36'sd14;
        27: r = 36'sd7;         28: r = 36'sd4;         29: r = 36'sd2;
        30: r = 36'sd1;         default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [CsW-1:0] rnd30(input logic signed [67:0] p);
    logic signed [67:0] t;
    begin
      t = p + 68'sd536870912;
      return CsW'(t >>> 30);
    end
  endfunction
endpackage
`default_nettype wire

// ----- design/v3rot_if.sv -----
// Valid/ready channel interfaces of the rotation unit.
// Depends on nothing but the width parameter.
`default_nettype none
interface v3rot_in_if #(parameter int W = 32);
  logic valid, ready;
  logic [1:0] operation;
  logic signed [W-1:0] in_x, in_y, in_z;
  logic signed [31:0] axis_x, axis_y, axis_z;
  logic signed [25:0] angle;
  modport source (output valid, operation, in_x, in_y, in_z, axis_x, axis_y, axis_z, angle,
    input ready);
  modport sink (input valid, operation, in_x, in_y, in_z, axis_x, axis_y, axis_z, angle,
    output ready);
endinterface

interface v3rot_out_if #(parameter int W = 32);
  logic valid, ready;
  logic signed [W-1:0] out_x, out_y, out_z;
  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface
`default_nettype wire

// ----- design/v3rot_cell.sv -----
// One CORDIC cell: a single micro-rotation with a register stage.
// Depends on v3rot_pkg.
`default_nettype none
module v3rot_cell
  import v3rot_pkg::*;
#(parameter int IDX = 0, parameter int PW = 96) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [CsW-1:0] x_i,
  input  wire logic signed [CsW-1:0] y_i,
  input  wire logic signed [ZW-1:0]  z_i,
  input  wire logic [PW-1:0]         p_i,
  output logic signed [CsW-1:0]      x_o,
  output logic signed [CsW-1:0]      y_o,
  output logic signed [ZW-1:0]       z_o,
  output logic [PW-1:0]              p_o
);
  logic signed [CsW-1:0] x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic signed [CsW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [PW-1:0] p_r;

  always_comb begin
    if (!z_i[ZW-1]) begin
      x_nxt = x_i - (y_i >>> IDX);
      y_nxt = y_i + (x_i >>> IDX);
      z_nxt = z_i - atan_f(IDX);
    end else begin
      x_nxt = x_i + (y_i >>> IDX);
      y_nxt = y_i - (x_i >>> IDX);
      z_nxt = z_i + atan_f(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; p_r <= p_i;
    end
  end
  assign x_o = x_r; assign y_o = y_r; assign z_o = z_r; assign p_o = p_r;
endmodule
`default_nettype wire

// ----- design/v3rot_matrix.sv -----
// Matrix and product stages: builds the rotation matrix from sine and cosine
// and forms the saturated rotated vector. Depends on v3rot_pkg.
`default_nettype none
module v3rot_matrix
  import v3rot_pkg::*;
#(parameter int W = 32) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [CsW-1:0] s_i,
  input  wire logic signed [CsW-1:0] c_i,
  input  wire ctl_t                  ctl_i,
  input  wire logic signed [W-1:0]   vx_i,
  input  wire logic signed [W-1:0]   vy_i,
  input  wire logic signed [W-1:0]   vz_i,
  output logic signed [W-1:0]        ox_o,
  output logic signed [W-1:0]        oy_o,
  output logic signed [W-1:0]        oz_o
);
  localparam int PW = MW + W;
  localparam int AW = PW + 2;
  logic signed [CsW-1:0] s1_r, c1_r;
  ctl_t ctl1_r;
  logic signed [W-1:0] v1_r [3];
  logic signed [CsW-1:0] sx_r [3], w_r [3], c2_r, s2_r;
  ctl_t ctl2_r;
  logic signed [W-1:0] v2_r [3];
  logic signed [MW-1:0] m_r [3][3];
  logic signed [W-1:0] v3_r [3];
  logic signed [PW-1:0] p_r [3][3];
  logic signed [AW-1:0] a_r [3];
  logic signed [W-1:0] o_r [3];
  logic signed [CsW-1:0] u1 [3];
  logic signed [MW-1:0] m_nxt [3][3];

  always_comb begin
    u1[0] = CsW'(ctl1_r.ux); u1[1] = CsW'(ctl1_r.uy); u1[2] = CsW'(ctl1_r.uz);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= ctl_i.exact ? ctl_i.ex_s : (ctl_i.flip ? -s_i : s_i);
      c1_r <= ctl_i.exact ? ctl_i.ex_c : (ctl_i.flip ? -c_i : c_i);
      ctl1_r <= ctl_i;
      v1_r[0] <= vx_i; v1_r[1] <= vy_i; v1_r[2] <= vz_i;
      for (int i = 0; i < 3; i++) begin
        sx_r[i] <= rnd30(68'(s1_r) * 68'(u1[i]));
        w_r[i] <= rnd30(68'(OneQ30 - c1_r) * 68'(u1[i]));
        v2_r[i] <= v1_r[i];
      end
      c2_r <= c1_r; s2_r <= s1_r; ctl2_r <= ctl1_r;
      m_r <= m_nxt;
      v3_r <= v2_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) p_r[i][j] <= PW'(m_r[i][j]) * PW'(v3_r[j]);
        a_r[i] <= AW'(p_r[i][0]) + AW'(p_r[i][1]) + AW'(p_r[i][2]) + AW'(68'sd536870912);
      end
      for (int i = 0; i < 3; i++) begin
        if ((a_r[i] >>> 30) > AW'((64'sd1 <<< (W-1)) - 1))
          o_r[i] <= {1'b0, {(W-1){1'b1}}};
        else if ((a_r[i] >>> 30) < -AW'(64'sd1 <<< (W-1)))
          o_r[i] <= {1'b1, {(W-1){1'b0}}};
        else o_r[i] <= W'(a_r[i] >>> 30);
      end
    end
  end

  always_comb begin
    logic signed [CsW-1:0] u2 [3];
    logic signed [MW-1:0] c, s;
    u2[0] = CsW'(ctl2_r.ux); u2[1] = CsW'(ctl2_r.uy); u2[2] = CsW'(ctl2_r.uz);
    c = MW'(c2_r); s = MW'(s2_r);
    for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) m_nxt[i][j] = '0;
    unique case (ctl2_r.op)
      OP_ROT_X: begin
        m_nxt[0][0] = MW'(OneQ30); m_nxt[1][1] = c; m_nxt[1][2] = s;
        m_nxt[2][1] = -s; m_nxt[2][2] = c;
      end
      OP_ROT_Y: begin
        m_nxt[0][0] = c; m_nxt[0][2] = -s; m_nxt[1][1] = MW'(OneQ30);
        m_nxt[2][0] = s; m_nxt[2][2] = c;
      end
      OP_ROT_Z: begin
        m_nxt[0][0] = c; m_nxt[0][1] = s; m_nxt[1][0] = -s; m_nxt[1][1] = c;
        m_nxt[2][2] = MW'(OneQ30);
      end
      default: begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            m_nxt[i][j] = MW'(rnd30(68'(u2[j]) * 68'(w_r[i])));
        m_nxt[0][0] += c; m_nxt[0][1] += MW'(sx_r[2]); m_nxt[0][2] -= MW'(sx_r[1]);
        m_nxt[1][0] -= MW'(sx_r[2]); m_nxt[1][1] += c; m_nxt[1][2] += MW'(sx_r[0]);
        m_nxt[2][0] += MW'(sx_r[1]); m_nxt[2][1] -= MW'(sx_r[0]); m_nxt[2][2] += c;
      end
    endcase
  end

  assign ox_o = o_r[0]; assign oy_o = o_r[1]; assign oz_o = o_r[2];
endmodule
`default_nettype wire

// ----- design/vector3_axis_rotation_unit.sv -----
// Rotates a 3D vector about x, y, z or a given unit axis. One item is accepted
// every clock cycle unless the output item is stalled. The pipe is one input
// stage, the chain of CORDIC cells (one micro-rotation each) and six matrix and
// product stages. The whole pipe advances together and holds while the output item
// is not taken.
`default_nettype none
`include "assert_macros.svh"
module vector3_axis_rotation_unit
  import v3rot_pkg::*;
#(parameter int COORD_WIDTH = 32, parameter int CORDIC_STAGES = 24) (
  input wire logic clk,
  input wire logic rst_n,
  v3rot_in_if.sink  in_ch,
  v3rot_out_if.source out_ch
);
  localparam int N = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int LAT = N + 7;
  localparam int PW = $bits(ctl_t) + 3 * COORD_WIDTH;

  logic [LAT-1:0] vld_r;
  logic en;
  assign en = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_ch.valid};
  end

  // Input stage: axis clamp, angle reduction and exact-angle detection.
  ctl_t ctl_nxt, ctl_r;
  logic signed [ZW-1:0] z_nxt, z0_r;
  logic [3*COORD_WIDTH-1:0] v0_r;
  always_comb begin
    logic signed [ZW-1:0] r;
    logic signed [AxisW:0] u [3];
    u[0] = in_ch.axis_x; u[1] = in_ch.axis_y; u[2] = in_ch.axis_z;
    for (int i = 0; i < 3; i++) begin
      if (u[i] > 33'sd1073741824) u[i] = 33'sd1073741824;
      else if (u[i] < -33'sd1073741824) u[i] = -33'sd1073741824;
    end
    r = ZW'(in_ch.angle);
    if (r > Deg180) r = r - Deg360;
    else if (r <= -Deg180) r = r + Deg360;
    if (r > Deg180) r = r - Deg360;
    else if (r <= -Deg180) r = r + Deg360;
    ctl_nxt.flip = 1'b0;
    if (r > Deg90) begin
      r = r - Deg180; ctl_nxt.flip = 1'b1;
    end else if (r < -Deg90) begin
      r = r + Deg180; ctl_nxt.flip = 1'b1;
    end
    z_nxt = r <<< 8;
    ctl_nxt.op = op_t'(in_ch.operation);
    ctl_nxt.exact = 1'b0; ctl_nxt.ex_s = '0; ctl_nxt.ex_c = '0;
    if (in_ch.operation != OP_AXIS && ZW'(in_ch.angle) == Deg90) begin
      ctl_nxt.exact = 1'b1; ctl_nxt.ex_s = OneQ30;
    end else if (in_ch.operation != OP_AXIS && ZW'(in_ch.angle) == Deg180) begin
      ctl_nxt.exact = 1'b1; ctl_nxt.ex_c = -OneQ30;
    end
    ctl_nxt.ux = AxisW'(u[0]); ctl_nxt.uy = AxisW'(u[1]); ctl_nxt.uz = AxisW'(u[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_nxt; z0_r <= z_nxt;
      v0_r <= {in_ch.in_x, in_ch.in_y, in_ch.in_z};
    end
  end

  logic signed [CsW-1:0] cx [N+1], cy [N+1];
  logic signed [ZW-1:0] cz [N+1];
  logic [PW-1:0] cp [N+1];
  assign cx[0] = InvGain; assign cy[0] = '0; assign cz[0] = z0_r;
  assign cp[0] = {ctl_r, v0_r};

  for (genvar g = 0; g < N; g++) begin : g_cell
    v3rot_cell #(.IDX(g), .PW(PW)) u_cell (
      .clk(clk), .en(en), .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]), .p_i(cp[g]),
      .x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1]), .p_o(cp[g+1]));
  end

  ctl_t ctl_e;
  assign ctl_e = cp[N][PW-1 -: $bits(ctl_t)];

  v3rot_matrix #(.W(COORD_WIDTH)) u_matrix (
    .clk(clk), .en(en), .s_i(cy[N]), .c_i(cx[N]), .ctl_i(ctl_e),
    .vx_i(cp[N][3*COORD_WIDTH-1 -: COORD_WIDTH]),
    .vy_i(cp[N][2*COORD_WIDTH-1 -: COORD_WIDTH]),
    .vz_i(cp[N][COORD_WIDTH-1 -: COORD_WIDTH]),
    .ox_o(out_ch.out_x), .oy_o(out_ch.out_y), .oz_o(out_ch.out_z));

  `ASSERT_IMPL(a_stall_hold, clk, rst_n, out_ch.valid && !out_ch.ready, !in_ch.ready,
    "Pipe accepts an item while the output item is stalled.")
  `ASSERT_NEXT(a_enter, clk, rst_n, in_ch.valid && in_ch.ready, vld_r[0],
    "Accepted item did not enter the pipe.")
  `ASSERT_NEXT(a_drain, clk, rst_n, out_ch.valid && out_ch.ready && !vld_r[LAT-2],
    !out_ch.valid, "Output item repeated.")
endmodule
`default_nettype wire
